>>> rtl/eed_pkg.sv
// Shared types and sizing constants for the echo escape decoder.
`default_nettype none

package eed_pkg;

    localparam int MAX_BYTES = 4;
    localparam int IDX_W     = $clog2(MAX_BYTES);
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);

    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_done;
        logic       cut_short;
        logic       run_last;
    } out_item_t;

    // Results caused by one input item: count bytes, then an optional close.
    typedef struct packed {
        logic [CNT_W-1:0]            count;
        logic [MAX_BYTES-1:0][7:0]   bytes;
        logic                        close;
        logic                        cut;
    } bundle_t;

    typedef struct packed {
        logic    empty;
        logic    full;
        bundle_t head;
    } q_status_t;

endpackage

`default_nettype wire

>>> rtl/echo_escape_decoder_unit.sv
// Echo escape decoder: top level joining front end, bundle queue and back end.
// Usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_data) sets escape decoding on or off;
//   cfg_ready is always high. Write it only while the block is idle.
//   req channel takes one item per cycle while the queue is not full: a string byte and its end flag.
//   rsp channel gives the results: decoded bytes, then a closing item per
//   string carrying string_done and cut_short; run_last marks the final
//   result caused by each input item.
// The bundle of an accepted item is registered in the queue; its results are offered from the queue head.
// Throughput: one item per cycle while each item yields at most one result and the
//   receiver is ready; an item with several results holds the result port until all
//   are taken, and the four-entry bundle queue absorbs these bursts.
// Items that yield no result (a backslash, an escape in progress, bytes after
//   \c) are consumed without entering the queue.
// Receiver stall: results wait in the queue; req_ready drops only when the
//   queue is full.
// Reset: escapes off, plain text mode, queue empty.
`default_nettype none

module echo_escape_decoder_unit
    import eed_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cfg_valid,
    output logic          cfg_ready,
    input  wire logic     cfg_data,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire in_item_t req_item,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output out_item_t     rsp_item
);

    logic      push;
    bundle_t   push_data;
    logic      pop;
    q_status_t status;

    eed_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .q_full    (status.full),
        .push      (push),
        .push_data (push_data)
    );

    eed_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .status    (status)
    );

    eed_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (status),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

endmodule

`default_nettype wire

>>> rtl/eed_front.sv
// Front end: escape decode state machine, turns each item into a result bundle.
`default_nettype none

module eed_front
    import eed_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cfg_valid,
    output logic          cfg_ready,
    input  wire logic     cfg_data,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire in_item_t req_item,
    input  wire logic     q_full,
    output logic          push,
    output bundle_t       push_data
);

    localparam logic [2:0] M_PLAIN = 3'd0;
    localparam logic [2:0] M_ESC   = 3'd1;
    localparam logic [2:0] M_OCT   = 3'd2;
    localparam logic [2:0] M_HEX0  = 3'd3;
    localparam logic [2:0] M_HEX1  = 3'd4;

    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_B    = 8'h62;
    localparam logic [7:0] CH_C    = 8'h63;
    localparam logic [7:0] CH_E    = 8'h65;
    localparam logic [7:0] CH_F    = 8'h66;
    localparam logic [7:0] CH_N    = 8'h6E;
    localparam logic [7:0] CH_R    = 8'h72;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_V    = 8'h76;
    localparam logic [7:0] CH_ZERO = 8'h30;

    localparam logic [7:0] BEL = 8'h07;
    localparam logic [7:0] BS  = 8'h08;
    localparam logic [7:0] ESC = 8'h1B;
    localparam logic [7:0] FF  = 8'h0C;
    localparam logic [7:0] LF  = 8'h0A;
    localparam logic [7:0] CR  = 8'h0D;
    localparam logic [7:0] HT  = 8'h09;
    localparam logic [7:0] VT  = 8'h0B;

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    logic        esc_en_reg;
    logic [2:0]  mode_reg, mode_next;
    logic [8:0]  oval_reg, oval_next;
    logic [1:0]  ocnt_reg, ocnt_next;
    logic [7:0]  held_reg, held_next;
    logic        stopped_reg, stopped_next;

    logic [CNT_W-1:0]          n_v;
    logic [MAX_BYTES-1:0][7:0] bytes_v;
    logic                      close_v;
    logic                      cut_v;
    logic [7:0]                b;
    logic [4:0]                hb;
    logic [4:0]                hh;
    logic                      accept;

    assign cfg_ready = 1'b1;
    assign req_ready = !q_full;
    assign accept    = req_valid && req_ready;
    assign b         = req_item.in_byte;
    assign hb        = hex_digit(b);
    assign hh        = hex_digit(held_reg);

    always_comb
    begin
        mode_next    = mode_reg;
        oval_next    = oval_reg;
        ocnt_next    = ocnt_reg;
        held_next    = held_reg;
        stopped_next = stopped_reg;
        n_v          = '0;
        bytes_v      = '0;
        close_v      = 1'b0;
        cut_v        = 1'b0;

        if (!stopped_next)
        begin
            if (esc_en_reg)
            begin
                unique case (mode_next)
                    M_ESC:
                    begin
                        mode_next = M_PLAIN;
                        unique case (b)
                            CH_A: begin bytes_v[n_v[IDX_W-1:0]] = BEL; n_v = n_v + CNT_W'(1); end
                            CH_B: begin bytes_v[n_v[IDX_W-1:0]] = BS;  n_v = n_v + CNT_W'(1); end
                            CH_E: begin bytes_v[n_v[IDX_W-1:0]] = ESC; n_v = n_v + CNT_W'(1); end
                            CH_F: begin bytes_v[n_v[IDX_W-1:0]] = FF;  n_v = n_v + CNT_W'(1); end
                            CH_N: begin bytes_v[n_v[IDX_W-1:0]] = LF;  n_v = n_v + CNT_W'(1); end
                            CH_R: begin bytes_v[n_v[IDX_W-1:0]] = CR;  n_v = n_v + CNT_W'(1); end
                            CH_T: begin bytes_v[n_v[IDX_W-1:0]] = HT;  n_v = n_v + CNT_W'(1); end
                            CH_V: begin bytes_v[n_v[IDX_W-1:0]] = VT;  n_v = n_v + CNT_W'(1); end
                            CH_C: stopped_next = 1'b1;
                            CH_ZERO:
                            begin
                                mode_next = M_OCT;
                                oval_next = '0;
                                ocnt_next = '0;
                            end
                            CH_X: mode_next = M_HEX0;
                            default:
                            begin
                                bytes_v[n_v[IDX_W-1:0]] = b;
                                n_v = n_v + CNT_W'(1);
                            end
                        endcase
                    end
                    M_OCT:
                    begin
                        if (b[7:3] == 5'b00110)
                        begin
                            oval_next = {oval_next[5:0], b[2:0]};
                            ocnt_next = ocnt_next + 2'd1;
                            if (ocnt_next == 2'd3)
                            begin
                                bytes_v[n_v[IDX_W-1:0]] = oval_next[7:0];
                                n_v = n_v + CNT_W'(1);
                                mode_next = M_PLAIN;
                                oval_next = '0;
                                ocnt_next = '0;
                                held_next = '0;
                            end
                        end
                        else
                        begin
                            bytes_v[n_v[IDX_W-1:0]] = oval_next[7:0];
                            n_v = n_v + CNT_W'(1);
                            mode_next = M_PLAIN;
                            oval_next = '0;
                            ocnt_next = '0;
                            held_next = '0;
                            if (b == CH_BSL)
                            begin
                                mode_next = M_ESC;
                            end
                            else
                            begin
                                bytes_v[n_v[IDX_W-1:0]] = b;
                                n_v = n_v + CNT_W'(1);
                            end
                        end
                    end
                    M_HEX0:
                    begin
                        if (hb[4])
                        begin
                            held_next = b;
                            mode_next = M_HEX1;
                        end
                        else
                        begin
                            bytes_v[n_v[IDX_W-1:0]] = CH_X;
                            n_v = n_v + CNT_W'(1);
                            mode_next = M_PLAIN;
                            oval_next = '0;
                            ocnt_next = '0;
                            held_next = '0;
                            if (b == CH_BSL)
                            begin
                                mode_next = M_ESC;
                            end
                            else
                            begin
                                bytes_v[n_v[IDX_W-1:0]] = b;
                                n_v = n_v + CNT_W'(1);
                            end
                        end
                    end
                    M_HEX1:
                    begin
                        if (hb[4])
                        begin
                            bytes_v[n_v[IDX_W-1:0]] = {hh[3:0], hb[3:0]};
                            n_v = n_v + CNT_W'(1);
                        end
                        else
                        begin
                            bytes_v[n_v[IDX_W-1:0]] = CH_X;
                            n_v = n_v + CNT_W'(1);
                            bytes_v[n_v[IDX_W-1:0]] = held_next;
                            n_v = n_v + CNT_W'(1);
                        end
                        mode_next = M_PLAIN;
                        oval_next = '0;
                        ocnt_next = '0;
                        held_next = '0;
                        if (!hb[4])
                        begin
                            if (b == CH_BSL)
                            begin
                                mode_next = M_ESC;
                            end
                            else
                            begin
                                bytes_v[n_v[IDX_W-1:0]] = b;
                                n_v = n_v + CNT_W'(1);
                            end
                        end
                    end
                    default:
                    begin
                        mode_next = M_PLAIN;
                        oval_next = '0;
                        ocnt_next = '0;
                        held_next = '0;
                        if (b == CH_BSL)
                        begin
                            mode_next = M_ESC;
                        end
                        else
                        begin
                            bytes_v[n_v[IDX_W-1:0]] = b;
                            n_v = n_v + CNT_W'(1);
                        end
                    end
                endcase
            end
            else
            begin
                unique case (mode_next)
                    M_ESC:
                    begin
                        bytes_v[n_v[IDX_W-1:0]] = CH_BSL;
                        n_v = n_v + CNT_W'(1);
                    end
                    M_OCT:
                    begin
                        bytes_v[n_v[IDX_W-1:0]] = oval_next[7:0];
                        n_v = n_v + CNT_W'(1);
                    end
                    M_HEX0:
                    begin
                        bytes_v[n_v[IDX_W-1:0]] = CH_X;
                        n_v = n_v + CNT_W'(1);
                    end
                    M_HEX1:
                    begin
                        bytes_v[n_v[IDX_W-1:0]] = CH_X;
                        n_v = n_v + CNT_W'(1);
                        bytes_v[n_v[IDX_W-1:0]] = held_next;
                        n_v = n_v + CNT_W'(1);
                    end
                    default:
                    begin
                    end
                endcase
                mode_next = M_PLAIN;
                oval_next = '0;
                ocnt_next = '0;
                held_next = '0;
                bytes_v[n_v[IDX_W-1:0]] = b;
                n_v = n_v + CNT_W'(1);
            end
        end

        if (req_item.end_of_string)
        begin
            if (!stopped_next)
            begin
                unique case (mode_next)
                    M_ESC:
                    begin
                        bytes_v[n_v[IDX_W-1:0]] = CH_BSL;
                        n_v = n_v + CNT_W'(1);
                    end
                    M_OCT:
                    begin
                        bytes_v[n_v[IDX_W-1:0]] = oval_next[7:0];
                        n_v = n_v + CNT_W'(1);
                    end
                    M_HEX0:
                    begin
                        bytes_v[n_v[IDX_W-1:0]] = CH_X;
                        n_v = n_v + CNT_W'(1);
                    end
                    M_HEX1:
                    begin
                        bytes_v[n_v[IDX_W-1:0]] = CH_X;
                        n_v = n_v + CNT_W'(1);
                        bytes_v[n_v[IDX_W-1:0]] = held_next;
                        n_v = n_v + CNT_W'(1);
                    end
                    default:
                    begin
                    end
                endcase
            end
            close_v      = 1'b1;
            cut_v        = stopped_next;
            stopped_next = 1'b0;
            mode_next    = M_PLAIN;
            oval_next    = '0;
            ocnt_next    = '0;
            held_next    = '0;
        end
    end

    assign push            = accept && ((n_v != '0) || close_v);
    assign push_data.count = n_v;
    assign push_data.bytes = bytes_v;
    assign push_data.close = close_v;
    assign push_data.cut   = cut_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_en_reg  <= 1'b0;
            mode_reg    <= M_PLAIN;
            oval_reg    <= '0;
            ocnt_reg    <= '0;
            held_reg    <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                esc_en_reg <= cfg_data;
            end
            if (accept)
            begin
                mode_reg    <= mode_next;
                oval_reg    <= oval_next;
                ocnt_reg    <= ocnt_next;
                held_reg    <= held_next;
                stopped_reg <= stopped_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/eed_queue.sv
// Short bundle queue between the front end and the result sequencer.
`default_nettype none

module eed_queue
    import eed_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire bundle_t push_data,
    input  wire logic    pop,
    output q_status_t    status
);

    bundle_t              mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign status.head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + Q_CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - Q_CNT_W'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue pop while empty");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != Q_CNT_W'(Q_DEPTH)) && (count_reg != '0)
            |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with fill count");
`endif

endmodule

`default_nettype wire

>>> rtl/eed_back.sv
// Back end: steps through the head bundle and issues one result item per cycle while the receiver is ready.
`default_nettype none

module eed_back
    import eed_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire q_status_t status,
    output logic           pop,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output out_item_t      rsp_item
);

    logic [CNT_W-1:0] pos_reg, pos_next;
    logic             is_byte;
    logic             last;

    assign rsp_valid = !status.empty;
    assign is_byte   = (pos_reg < status.head.count);
    assign last      = is_byte
                     ? ((pos_reg == status.head.count - CNT_W'(1)) && !status.head.close)
                     : 1'b1;

    always_comb
    begin
        rsp_item.out_byte    = is_byte ? status.head.bytes[pos_reg[IDX_W-1:0]] : 8'h00;
        rsp_item.byte_valid  = is_byte;
        rsp_item.string_done = !is_byte;
        rsp_item.cut_short   = !is_byte && status.head.cut;
        rsp_item.run_last    = last;
    end

    assign pop = rsp_valid && rsp_ready && last;

    always_comb
    begin
        pos_next = pos_reg;
        if (rsp_valid && rsp_ready)
        begin
            pos_next = last ? '0 : pos_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

`ifndef ASSERT_OFF
    a_close_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.string_done |-> rsp_item.run_last)
        else $error("closing item not marked last");
    a_byte_not_close: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.byte_valid |-> !rsp_item.string_done && !rsp_item.cut_short)
        else $error("byte item carries close flags");
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (pos_reg <= status.head.count))
        else $error("result position past bundle");
`endif

endmodule

`default_nettype wire
